/* rtl/pbfl_pkg.sv */
// ----------------------------------------------------------------------------
// pbfl_pkg
// Command and status codes shared by the priority bucket FIFO lister.
// ----------------------------------------------------------------------------
package pbfl_pkg;

    localparam int WORD_W = 64;
    localparam int PRIO_W = 8;

    typedef logic [1:0] t_code;

    // commands
    localparam t_code CMD_INSERT  = 2'd0;
    localparam t_code CMD_SHOW_EQ = 2'd1;
    localparam t_code CMD_SHOW_LE = 2'd2;

    // result status
    localparam t_code ST_STORED = 2'd0;
    localparam t_code ST_FULL   = 2'd1;
    localparam t_code ST_WORD   = 2'd2;
    localparam t_code ST_NONE   = 2'd3;

endpackage

/* rtl/pbfl_ram.sv */
// ----------------------------------------------------------------------------
// pbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/priority_bucket_fifo_lister.sv */
// ----------------------------------------------------------------------------
// priority_bucket_fifo_lister
// Per-priority word FIFOs chained through one shared store, with listings.
// ----------------------------------------------------------------------------
// One command is worked at a time; o_in_stall is high until its last result
// word has been placed in the output register. An insert does a tail lookup
// in the level RAMs, then a write, then gives its result. A listing scans the
// levels, testing one occupied flag per cycle, and for each occupied level met
// reads its head and walks its words, one link per cycle unless the output
// stalls, through the store and link RAMs, whose registered read port sets the
// pace. Store and level RAMs need no clearing after reset; only the occupied
// flags and the store count are cleared, at once.
module priority_bucket_fifo_lister #(
    parameter int CAPACITY = 64,
    parameter int LEVELS   = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [pbfl_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [pbfl_pkg::WORD_W-1:0]   i_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [pbfl_pkg::PRIO_W-1:0]   o_level,
    output logic [pbfl_pkg::WORD_W-1:0]   o_word_out,
    output logic                          o_last
);

    import pbfl_pkg::*;

    // only levels an 8-bit priority can name get storage
    localparam int NLEV = (LEVELS < (1 << PRIO_W)) ? LEVELS : (1 << PRIO_W);
    localparam int LW   = $clog2(NLEV);
    localparam int AW   = $clog2(CAPACITY);
    localparam int HW   = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_SCAN,
        S_HEAD,
        S_WORD,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [NLEV-1:0]     r_occ, n_occ;
    logic [HW-1:0]       r_held, n_held;
    logic [LW-1:0]       r_lv, n_lv;
    logic [LW-1:0]       r_bound, n_bound;
    logic [AW-1:0]       r_e, n_e;
    logic [AW-1:0]       r_tail, n_tail;
    logic [PRIO_W-1:0]   r_pr, n_pr;
    logic [WORD_W-1:0]   r_word, n_word;
    t_code               r_fin_status, n_fin_status;
    logic                r_hold_v, n_hold_v;
    logic [LW-1:0]       r_hold_lv, n_hold_lv;
    logic [WORD_W-1:0]   r_hold_word, n_hold_word;
    logic                r_out_valid, n_out_valid;
    t_code               r_status, n_status;
    logic [PRIO_W-1:0]   r_level, n_level;
    logic [WORD_W-1:0]   r_word_out, n_word_out;
    logic                r_last, n_last;

    logic                out_free;
    logic                pr_over;
    logic [LW-1:0]       pr_lv;

    logic                word_we, link_we, head_we, tail_we;
    logic [AW-1:0]       link_waddr;
    logic [AW-1:0]       store_raddr;
    logic [WORD_W-1:0]   word_rdata;
    logic [AW-1:0]       link_rdata, head_rdata, tail_rdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pr_over  = 32'(i_priority_req) >= 32'(LEVELS);
    assign pr_lv    = i_priority_req[LW-1:0];

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_held       = r_held;
        n_lv         = r_lv;
        n_bound      = r_bound;
        n_e          = r_e;
        n_tail       = r_tail;
        n_pr         = r_pr;
        n_word       = r_word;
        n_fin_status = r_fin_status;
        n_hold_v     = r_hold_v;
        n_hold_lv    = r_hold_lv;
        n_hold_word  = r_hold_word;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_level      = r_level;
        n_word_out   = r_word_out;
        n_last       = r_last;
        word_we      = 1'b0;
        link_we      = 1'b0;
        head_we      = 1'b0;
        tail_we      = 1'b0;
        link_waddr   = tail_rdata;
        store_raddr  = r_e;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pr     = i_priority_req;
                    n_word   = i_word;
                    n_hold_v = 1'b0;
                    case (i_command)
                        CMD_INSERT: begin
                            if (pr_over || r_held >= HW'(CAPACITY)) begin
                                n_fin_status = ST_FULL;
                                n_state      = S_FIN;
                            end else begin
                                n_lv    = pr_lv;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_SHOW_EQ: begin
                            n_fin_status = ST_NONE;
                            n_lv         = pr_lv;
                            n_bound      = pr_lv;
                            n_state      = pr_over ? S_FIN : S_SCAN;
                        end
                        CMD_SHOW_LE: begin
                            n_fin_status = ST_NONE;
                            n_lv         = '0;
                            n_bound      = pr_over ? LW'(NLEV - 1) : pr_lv;
                            n_state      = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_RD: begin
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                // store entries are handed out in order: next free is r_held
                word_we = 1'b1;
                tail_we = 1'b1;
                if (r_occ[r_lv]) begin
                    link_we = 1'b1;
                end else begin
                    head_we = 1'b1;
                end
                n_occ[r_lv]  = 1'b1;
                n_held       = r_held + 1'b1;
                n_fin_status = ST_STORED;
                n_state      = S_FIN;
            end
            S_SCAN: begin
                if (r_occ[r_lv]) begin
                    n_state = S_HEAD;
                end else if (r_lv == r_bound) begin
                    n_state = S_FIN;
                end else begin
                    n_lv = r_lv + 1'b1;
                end
            end
            S_HEAD: begin
                n_e         = head_rdata;
                n_tail      = tail_rdata;
                store_raddr = head_rdata;
                n_state     = S_WORD;
            end
            S_WORD: begin
                // one word is held back so the final one can carry last
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_WORD;
                        n_level     = PRIO_W'(r_hold_lv);
                        n_word_out  = r_hold_word;
                        n_last      = 1'b0;
                    end
                    n_hold_v    = 1'b1;
                    n_hold_lv   = r_lv;
                    n_hold_word = word_rdata;
                    if (r_e == r_tail) begin
                        if (r_lv == r_bound) begin
                            n_state = S_FIN;
                        end else begin
                            n_lv    = r_lv + 1'b1;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_e         = link_rdata;
                        store_raddr = link_rdata;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    if (r_hold_v) begin
                        n_status   = ST_WORD;
                        n_level    = PRIO_W'(r_hold_lv);
                        n_word_out = r_hold_word;
                    end else begin
                        n_status   = r_fin_status;
                        n_level    = r_pr;
                        n_word_out = '0;
                    end
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_held      <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_held      <= n_held;
            r_hold_v    <= n_hold_v;
            r_out_valid <= n_out_valid;
        end
        r_lv         <= n_lv;
        r_bound      <= n_bound;
        r_e          <= n_e;
        r_tail       <= n_tail;
        r_pr         <= n_pr;
        r_word       <= n_word;
        r_fin_status <= n_fin_status;
        r_hold_lv    <= n_hold_lv;
        r_hold_word  <= n_hold_word;
        r_status     <= n_status;
        r_level      <= n_level;
        r_word_out   <= n_word_out;
        r_last       <= n_last;
    end

    pbfl_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (r_held[AW-1:0]),
        .i_wdata (r_word),
        .i_raddr (store_raddr),
        .o_rdata (word_rdata)
    );

    pbfl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (r_held[AW-1:0]),
        .i_raddr (store_raddr),
        .o_rdata (link_rdata)
    );

    pbfl_ram #(.WIDTH(AW), .DEPTH(NLEV)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_lv),
        .i_wdata (r_held[AW-1:0]),
        .i_raddr (r_lv),
        .o_rdata (head_rdata)
    );

    pbfl_ram #(.WIDTH(AW), .DEPTH(NLEV)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (r_lv),
        .i_wdata (r_held[AW-1:0]),
        .i_raddr (r_lv),
        .o_rdata (tail_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_level     = r_level;
    assign o_word_out  = r_word_out;
    assign o_last      = r_last;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(CAPACITY))
        else $error("store count above capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_WR |=> r_held == $past(r_held) + 1'b1)
        else $error("insert did not advance store count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_WORD) |-> r_lv <= r_bound)
        else $error("level scan passed its bound");

    a_non_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_WORD) |-> o_last)
        else $error("single result word without last");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("listed word left behind after command");

endmodule
